// ===== rtl/tpfr_pkg.sv =====
// Shared types, constants and checksum helpers for the TCP port forwarding rewriter.
`default_nettype none

package tpfr_pkg;

  localparam logic [7:0] TcpProtocol = 8'd6;
  localparam logic [6:0] TcpHdrBytes = 7'd20;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgLocalIp    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLocalPort  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgTargetIp   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTargetPort = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTargetMac  = 3'd4;

  localparam logic [15:0] LocalPortRst  = 16'd8000;
  localparam logic [15:0] TargetPortRst = 16'd80;

  typedef enum logic [1:0] {
    ACT_PASS    = 2'd0,
    ACT_FORWARD = 2'd1,
    ACT_RETURN  = 2'd2
  } action_e;

  typedef struct packed {
    logic [7:0]  protocol;
    logic [3:0]  header_words;
    logic [15:0] total_length;
    logic [15:0] captured_length;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] ip_checksum;
    logic [15:0] tcp_checksum;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
  } in_word_t;

  typedef struct packed {
    action_e     action;
    logic [31:0] out_src_ip;
    logic [31:0] out_dst_ip;
    logic [15:0] out_src_port;
    logic [15:0] out_dst_port;
    logic [15:0] out_ip_checksum;
    logic [15:0] out_tcp_checksum;
    logic [47:0] out_src_mac;
    logic [47:0] out_dst_mac;
  } out_word_t;

  typedef struct packed {
    logic [31:0] local_ip;
    logic [15:0] local_port;
    logic [31:0] target_ip;
    logic [15:0] target_port;
    logic [47:0] target_mac;
  } cfg_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
  } client_t;

  typedef struct packed {
    logic    we;
    client_t client;
  } client_upd_t;

  // Plain sum of the four ones' complement terms that remove oldv and insert newv.
  function automatic logic [17:0] swap32_sum(logic [31:0] oldv, logic [31:0] newv);
    return {2'b00, ~oldv[31:16]} + {2'b00, ~oldv[15:0]} +
           {2'b00, newv[31:16]} + {2'b00, newv[15:0]};
  endfunction

  // Folds the end-around carries of a positive sum and complements it.
  // A positive sum folds to 1..0xFFFF, so the checksum is never 0xFFFF.
  function automatic logic [15:0] csum_finish(logic [19:0] sum);
    logic [16:0] fold1;
    logic [15:0] fold2;
    fold1 = {1'b0, sum[15:0]} + {13'b0, sum[19:16]};
    fold2 = fold1[15:0] + {15'b0, fold1[16]};
    return ~fold2;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tcp_port_forward_rewriter.sv =====
// Top level of the TCP port forwarding rewriter: pipeline registers and client state.
//
// Header words from a link parser enter on the in channel (valid/ready) and the
// rewritten header leaves on the out channel, one result word per input word.
// Configuration registers (local ip/port, target ip/port/mac) are written on the
// cfg channel, which is always ready; write them only while no word is in flight.
//
// A word is held in the input register, classified and
// rewritten by one pass of compare and checksum logic, and stored in the result
// register. Throughput is one word per cycle while the receiver does not stall, set by that single-pass stage.
// A forwarded word records its sender as the client when it leaves the input
// register, so the word behind it already sees the new client.
//
// When the receiver stalls, the result register holds its word and the input
// register can still take one more; ready drops once both are full.
// Reset empties both registers, restores the register defaults and clears the
// client to address zero and hardware address zero.
`default_nettype none

module tcp_port_forward_rewriter (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire tpfr_pkg::in_word_t           in_word_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output tpfr_pkg::out_word_t               out_word_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [tpfr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [47:0]                  cfg_data_i
);
  import tpfr_pkg::*;

  cfg_t        cfg;
  in_word_t    in_q;
  logic        in_vld_q;
  out_word_t   out_q, out_d;
  logic        out_vld_q;
  client_t     client_q;
  client_upd_t upd;
  logic        advance, res_free;

  assign cfg_ready_o = 1'b1;

  tpfr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i & cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  tpfr_rewrite u_rewrite (
    .word_i   (in_q),
    .cfg_i    (cfg),
    .client_i (client_q),
    .word_o   (out_d),
    .upd_o    (upd)
  );

  assign res_free   = !out_vld_q || out_ready_i;
  assign advance    = in_vld_q && res_free;
  assign in_ready_o = !in_vld_q || res_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      client_q  <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (res_free) begin
        out_vld_q <= in_vld_q;
      end
      if (advance && upd.we) begin
        client_q <= upd.client;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_word_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  a_client_only_on_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(client_q) |-> $past(advance && upd.we))
    else $error("client changed without a forwarded word");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("word left the input register but no result is valid");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && in_vld_q))
    else $error("input stalled while the pipeline has room");

  a_checksum_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.action != ACT_PASS) |->
      (out_word_o.out_ip_checksum != 16'hFFFF && out_word_o.out_tcp_checksum != 16'hFFFF))
    else $error("rewritten checksum in negative-zero form");

endmodule

`default_nettype wire

// ===== rtl/tpfr_cfg_regs.sv =====
// Configuration register file of the TCP port forwarding rewriter.
`default_nettype none

module tpfr_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         wr_en_i,
  input  wire logic [tpfr_pkg::CfgIdxW-1:0] wr_index_i,
  input  wire logic [47:0]                  wr_data_i,
  output tpfr_pkg::cfg_t                    cfg_o
);
  import tpfr_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        CfgLocalIp:    cfg_d.local_ip    = wr_data_i[31:0];
        CfgLocalPort:  cfg_d.local_port  = wr_data_i[15:0];
        CfgTargetIp:   cfg_d.target_ip   = wr_data_i[31:0];
        CfgTargetPort: cfg_d.target_port = wr_data_i[15:0];
        CfgTargetMac:  cfg_d.target_mac  = wr_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.local_ip    <= '0;
      cfg_q.local_port  <= LocalPortRst;
      cfg_q.target_ip   <= '0;
      cfg_q.target_port <= TargetPortRst;
      cfg_q.target_mac  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/tpfr_rewrite.sv =====
// Classification, header rewrite and incremental checksum update of one word.
`default_nettype none

module tpfr_rewrite (
  input  wire tpfr_pkg::in_word_t     word_i,
  input  wire tpfr_pkg::cfg_t         cfg_i,
  input  wire tpfr_pkg::client_t      client_i,
  output tpfr_pkg::out_word_t         word_o,
  output tpfr_pkg::client_upd_t       upd_o
);
  import tpfr_pkg::*;

  logic        is_tcp, len_ok, fwd_hit, ret_hit;
  logic [6:0]  min_len;
  logic [31:0] new_dst_ip;
  logic [15:0] old_port, new_port;
  logic [18:0] addr_sum;
  logic [19:0] ip_sum, tcp_sum;
  logic [15:0] ip_ck, tcp_ck;

  always_comb begin
    is_tcp  = (word_i.protocol == TcpProtocol);
    min_len = {1'b0, word_i.header_words, 2'b00} + TcpHdrBytes;
    len_ok  = (word_i.captured_length >= {9'b0, min_len}) &&
              (word_i.captured_length >= word_i.total_length);
    fwd_hit = is_tcp && len_ok && (word_i.dst_ip == cfg_i.local_ip) &&
              (word_i.dst_port == cfg_i.local_port);
    ret_hit = is_tcp && len_ok && !fwd_hit && (word_i.src_ip == cfg_i.target_ip) &&
              (word_i.src_port == cfg_i.target_port) && (word_i.dst_ip == cfg_i.local_ip);

    // In the checksum arithmetic, forward and return differ only in the new destination and in which port changes.
    new_dst_ip = fwd_hit ? cfg_i.target_ip : client_i.ip;
    old_port   = fwd_hit ? word_i.dst_port : word_i.src_port;
    new_port   = fwd_hit ? cfg_i.target_port : cfg_i.local_port;

    addr_sum = {1'b0, swap32_sum(word_i.dst_ip, new_dst_ip)} +
               {1'b0, swap32_sum(word_i.src_ip, cfg_i.local_ip)};
    ip_sum   = {1'b0, addr_sum} + 20'h0FFFF + {4'b0, ~word_i.ip_checksum};
    tcp_sum  = {1'b0, addr_sum} + 20'h0FFFF + {4'b0, ~word_i.tcp_checksum} +
               {4'b0, ~old_port} + {4'b0, new_port};
    ip_ck    = csum_finish(ip_sum);
    tcp_ck   = csum_finish(tcp_sum);

    word_o.action           = ACT_PASS;
    word_o.out_src_ip       = word_i.src_ip;
    word_o.out_dst_ip       = word_i.dst_ip;
    word_o.out_src_port     = word_i.src_port;
    word_o.out_dst_port     = word_i.dst_port;
    word_o.out_ip_checksum  = word_i.ip_checksum;
    word_o.out_tcp_checksum = word_i.tcp_checksum;
    word_o.out_src_mac      = word_i.src_mac;
    word_o.out_dst_mac      = word_i.dst_mac;

    if (fwd_hit) begin
      word_o.action       = ACT_FORWARD;
      word_o.out_dst_port = cfg_i.target_port;
      word_o.out_dst_mac  = cfg_i.target_mac;
    end else if (ret_hit) begin
      word_o.action       = ACT_RETURN;
      word_o.out_src_port = cfg_i.local_port;
      word_o.out_dst_mac  = client_i.mac;
    end
    if (fwd_hit || ret_hit) begin
      word_o.out_src_ip       = cfg_i.local_ip;
      word_o.out_dst_ip       = new_dst_ip;
      word_o.out_ip_checksum  = ip_ck;
      word_o.out_tcp_checksum = tcp_ck;
      word_o.out_src_mac      = word_i.dst_mac;
    end

    upd_o.we         = fwd_hit;
    upd_o.client.ip  = word_i.src_ip;
    upd_o.client.mac = word_i.src_mac;
  end

endmodule

`default_nettype wire
